>>> sv/swt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swt_pkg;

    localparam int TIME_W  = 48;
    localparam int GEN_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CNT_W   = 4;
    localparam int PROD_W  = CFG_W + CNT_W;
    localparam int STAT_W  = 3;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 128;

    localparam logic [CNT_W-1:0] SLICE_CAP = CNT_W'(5);

    localparam logic [CFG_W-1:0] TOTAL_RESET = CFG_W'(7300000);
    localparam logic [CFG_W-1:0] SLICE_RESET = CFG_W'(1460000);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOTAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SLICE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_BEGIN   = 2'd0,
        MODE_POLL    = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_QUERY   = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_ACTIVE     = 3'd1,
        ST_NOT_ACTIVE = 3'd2,
        ST_CLOCK      = 3'd3,
        ST_SEGMENT    = 3'd4,
        ST_EARLY      = 3'd5
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic [TIME_W-1:0]  now_ms;
        logic [GEN_W-1:0]   request_generation;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] total_duration_ms;
        logic [CFG_W-1:0] slice_len;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic               boundary_reached;
        logic               is_active;
        logic               has_begun;
        logic [TIME_W-1:0]  elapsed_time;
        logic               ready_res;
        logic [CNT_W-1:0]   slice_total;
        logic [GEN_W-1:0]   current_generation;
        logic [CFG_W-1:0]   deadline_offset;
    } res_t;

endpackage

`default_nettype wire

>>> sv/swt_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module swt_in_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire swt_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_take,
    output swt_pkg::cmd_t      out_cmd
);

    logic          valid_reg;
    logic          valid_next;
    swt_pkg::cmd_t cmd_reg;
    logic          load;

    // A new word may enter in the same cycle the held one moves on.
    assign in_ready = !valid_reg || out_take;
    assign load     = in_valid && in_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (out_take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= in_cmd;
        end
    end

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;

endmodule

`default_nettype wire

>>> sv/swt_core.sv
`timescale 1ns / 1ps
`default_nettype none

module swt_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    input  wire swt_pkg::cmd_t cmd,
    output logic               cmd_take,
    input  wire swt_pkg::cfg_t cfg,
    input  wire logic          res_ready,
    output swt_pkg::res_t      res
);

    logic                            active_reg, active_next;
    logic                            started_reg, started_next;
    logic [swt_pkg::TIME_W-1:0]      start_reg, start_next;
    logic [swt_pkg::TIME_W-1:0]      last_reg, last_next;
    logic [swt_pkg::GEN_W-1:0]       gen_reg, gen_next;
    logic [swt_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [swt_pkg::CFG_W-1:0]       deadline_reg, deadline_next;

    logic                            fire;
    logic                            clk_ok;
    logic [swt_pkg::TIME_W-1:0]      spent_raw;
    logic [swt_pkg::TIME_W-1:0]      pre_spent;
    logic [swt_pkg::TIME_W-1:0]      total_ext;
    logic                            pre_ge_total;
    logic [swt_pkg::CNT_W-1:0]       cnt_inc;
    logic [swt_pkg::PROD_W-1:0]      prod;
    logic                            prod_lt_total;
    logic [swt_pkg::CFG_W-1:0]       new_deadline;
    logic                            spent_ge_prod;
    logic                            spent_ge_dl;
    logic                            new_seg;
    logic                            seg_bad;
    logic                            begin_ok;
    logic [swt_pkg::TIME_W-1:0]      post_spent;
    logic                            post_ok;
    swt_pkg::status_t                status_next;
    logic                            boundary_next;

    assign fire     = cmd_valid && res_ready;
    assign cmd_take = fire;

    // The clock is consistent when nothing was started or when the stamp is
    // not behind either the start or the last accepted poll.
    assign clk_ok    = !started_reg ||
                       (cmd.now_ms >= start_reg && cmd.now_ms >= last_reg);
    assign spent_raw = cmd.now_ms - start_reg;
    assign pre_spent = (started_reg && clk_ok) ? spent_raw : '0;
    assign total_ext = swt_pkg::TIME_W'(cfg.total_duration_ms);
    assign pre_ge_total = pre_spent >= total_ext;

    assign cnt_inc       = cnt_reg + swt_pkg::CNT_W'(1);
    assign prod          = swt_pkg::PROD_W'(cfg.slice_len) * swt_pkg::PROD_W'(cnt_inc);
    assign prod_lt_total = prod < swt_pkg::PROD_W'(cfg.total_duration_ms);
    assign new_deadline  = prod_lt_total ? prod[swt_pkg::CFG_W-1:0]
                                         : cfg.total_duration_ms;

    // Reaching min(prod, total) is the same as reaching either one, which
    // keeps the multiply and the boundary compare side by side.
    assign spent_ge_prod = pre_spent >= swt_pkg::TIME_W'(prod);
    assign spent_ge_dl   = pre_spent >= swt_pkg::TIME_W'(deadline_reg);

    assign new_seg = cmd.request_generation != gen_reg;
    assign seg_bad = (cmd.request_generation < gen_reg) ||
                     (cnt_reg >= swt_pkg::SLICE_CAP) ||
                     ((gen_reg != '0) && !spent_ge_dl);

    always_comb begin
        active_next   = active_reg;
        started_next  = started_reg;
        start_next    = start_reg;
        last_next     = last_reg;
        gen_next      = gen_reg;
        cnt_next      = cnt_reg;
        deadline_next = deadline_reg;
        status_next   = swt_pkg::ST_OK;
        boundary_next = 1'b0;
        begin_ok      = 1'b0;
        unique case (cmd.mode)
            swt_pkg::MODE_BEGIN: begin
                if (active_reg) begin
                    status_next = swt_pkg::ST_ACTIVE;
                end else begin
                    begin_ok      = 1'b1;
                    start_next    = cmd.now_ms;
                    last_next     = cmd.now_ms;
                    gen_next      = '0;
                    cnt_next      = '0;
                    deadline_next = '0;
                    active_next   = 1'b1;
                    started_next  = 1'b1;
                end
            end
            swt_pkg::MODE_POLL: begin
                if (!active_reg || cmd.request_generation == '0) begin
                    status_next = swt_pkg::ST_NOT_ACTIVE;
                end else if (!clk_ok) begin
                    status_next = swt_pkg::ST_CLOCK;
                end else if (new_seg && seg_bad) begin
                    status_next = swt_pkg::ST_SEGMENT;
                end else begin
                    last_next = cmd.now_ms;
                    if (new_seg) begin
                        gen_next      = cmd.request_generation;
                        cnt_next      = cnt_inc;
                        deadline_next = new_deadline;
                        boundary_next = spent_ge_prod || pre_ge_total;
                    end else begin
                        boundary_next = spent_ge_dl;
                    end
                end
            end
            swt_pkg::MODE_RESTART: begin
                if (!active_reg) begin
                    status_next = swt_pkg::ST_EARLY;
                end else if (!clk_ok) begin
                    status_next = swt_pkg::ST_CLOCK;
                end else if (!pre_ge_total) begin
                    status_next = swt_pkg::ST_EARLY;
                end else begin
                    active_next = 1'b0;
                    last_next   = cmd.now_ms;
                end
            end
            swt_pkg::MODE_QUERY: begin
                if (!clk_ok) begin
                    status_next = swt_pkg::ST_CLOCK;
                end
            end
            default: begin
                status_next = swt_pkg::ST_OK;
            end
        endcase
    end

    // Only a fresh begin changes the elapsed view; every other accepted
    // update keeps start and leaves last at or below the stamp.
    assign post_spent = begin_ok ? '0 : pre_spent;
    assign post_ok    = begin_ok || clk_ok;

    always_comb begin
        res.status             = status_next;
        res.boundary_reached   = boundary_next;
        res.is_active          = active_next;
        res.has_begun          = started_next;
        res.elapsed_time       = post_spent;
        res.ready_res          = active_next && post_ok && (post_spent >= total_ext);
        res.slice_total        = cnt_next;
        res.current_generation = gen_next;
        res.deadline_offset    = deadline_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            started_reg  <= 1'b0;
            start_reg    <= '0;
            last_reg     <= '0;
            gen_reg      <= '0;
            cnt_reg      <= '0;
            deadline_reg <= '0;
        end else if (fire) begin
            active_reg   <= active_next;
            started_reg  <= started_next;
            start_reg    <= start_next;
            last_reg     <= last_next;
            gen_reg      <= gen_next;
            cnt_reg      <= cnt_next;
            deadline_reg <= deadline_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= swt_pkg::SLICE_CAP)
        else $error("slice count beyond limit");

    a_active_started: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> started_reg)
        else $error("active without a recorded start");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && status_next != swt_pkg::ST_OK |=>
            $stable(active_reg) && $stable(gen_reg) && $stable(cnt_reg) &&
            $stable(deadline_reg) && $stable(last_reg) && $stable(start_reg))
        else $error("rejected command changed state");

    a_begin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && begin_ok |=> active_reg && cnt_reg == '0 && gen_reg == '0)
        else $error("begin did not open a fresh wait");
`endif

endmodule

`default_nettype wire

>>> sv/swt_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module swt_out_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    output logic               can_load,
    input  wire swt_pkg::res_t in_res,
    output logic               out_valid,
    input  wire logic          out_ready,
    output swt_pkg::res_t      out_res
);

    logic          valid_reg;
    logic          valid_next;
    swt_pkg::res_t res_reg;

    assign can_load = !valid_reg || out_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= in_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

>>> sv/segmented_wait_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Tracks one long wait cut into numbered segments. Each word on the s_ channel
// is a command (begin, poll, restart done, status query) with a millisecond
// stamp and a segment generation; each command yields exactly one result word
// on the m_ channel with a status code and a snapshot of the tracker state.
// Two registers, the total duration and the slice length, are written through
// the cfg_ port; the user must do so only while no command is in flight, as the
// block does not enforce it. A command is held in the input register, then the
// state update and result are computed combinationally into the result register.
// Throughput is one command per cycle while m_tready is high; the slice multiply
// (32 by 4 bits) and the 48-bit elapsed subtract and compares set the logic depth.
// Reset clears the wait (not active, not begun, all counters zero) and loads
// the default durations. When m_tready is low the result register holds its
// word; one more command is taken into the input register, after which
// s_tready drops until the result moves on.
module segmented_wait_tracker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // now_ms[47:0], request_generation[79:48]
    input  wire logic [swt_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode[1:0]
    input  wire logic [swt_pkg::MODE_W-1:0]         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // status[2:0], boundary_reached[3], is_active[4], has_begun[5],
    // elapsed_time[53:6], ready_res[54], slice_total[58:55],
    // current_generation[90:59], deadline_offset[122:91], zero[127:123]
    output logic [swt_pkg::M_TDATA_W-1:0]           m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [swt_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [swt_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int RES_W = $bits(swt_pkg::res_t);

    logic [swt_pkg::CFG_W-1:0] total_reg;
    logic [swt_pkg::CFG_W-1:0] slice_reg;
    swt_pkg::cfg_t             cfg;

    swt_pkg::cmd_t in_cmd;
    swt_pkg::cmd_t held_cmd;
    logic          held_valid;
    logic          cmd_take;
    logic          res_can_load;
    swt_pkg::res_t core_res;
    swt_pkg::res_t out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= swt_pkg::TOTAL_RESET;
            slice_reg <= swt_pkg::SLICE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                swt_pkg::CFG_IDX_TOTAL: total_reg <= cfg_wdata;
                swt_pkg::CFG_IDX_SLICE: slice_reg <= cfg_wdata;
                default: total_reg <= total_reg;
            endcase
        end
    end

    assign cfg.total_duration_ms = total_reg;
    assign cfg.slice_len         = slice_reg;

    assign in_cmd.mode               = swt_pkg::mode_t'(s_tuser);
    assign in_cmd.now_ms             = s_tdata[swt_pkg::TIME_W-1:0];
    assign in_cmd.request_generation =
        s_tdata[swt_pkg::TIME_W + swt_pkg::GEN_W - 1:swt_pkg::TIME_W];

    swt_in_reg u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .out_valid (held_valid),
        .out_take  (cmd_take),
        .out_cmd   (held_cmd)
    );

    swt_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (held_valid),
        .cmd       (held_cmd),
        .cmd_take  (cmd_take),
        .cfg       (cfg),
        .res_ready (res_can_load),
        .res       (core_res)
    );

    swt_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (cmd_take),
        .can_load  (res_can_load),
        .in_res    (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {
        {(swt_pkg::M_TDATA_W - RES_W){1'b0}},
        out_res.deadline_offset,
        out_res.current_generation,
        out_res.slice_total,
        out_res.ready_res,
        out_res.elapsed_time,
        out_res.has_begun,
        out_res.is_active,
        out_res.boundary_reached,
        out_res.status
    };

endmodule

`default_nettype wire
